// ===== rtl/core/kmau_pkg.sv =====
// Package: shared types and constants for the k-means assign/update unit.
package kmau_pkg;

  localparam int unsigned MaxClustersDef = 16;
  localparam int unsigned CoordW = 16;
  localparam int unsigned SumW   = 36;
  localparam int unsigned CntW   = 21;
  localparam int unsigned ModeW  = 2;
  localparam int unsigned PrevW  = 5;
  localparam int unsigned LoadW  = 4;
  localparam int unsigned ClusW  = 4;
  localparam int unsigned NumCfgW = 5;
  localparam logic [NumCfgW-1:0] NumClustersRst = NumCfgW'(4);

  localparam logic [ModeW-1:0] ModeLoad   = 2'd0;
  localparam logic [ModeW-1:0] ModePoint  = 2'd1;
  localparam logic [ModeW-1:0] ModeFinish = 2'd2;
  localparam logic [ModeW-1:0] ModeNop    = 2'd3;

  // One classified command handed from the front end to the back end.
  typedef struct packed {
    logic [ModeW-1:0]  mode;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [PrevW-1:0]  prev;
    logic [LoadW-1:0]  idx;
  } cmd_t;

  typedef enum logic [2:0] {
    StIdle, StSearch, StEmitPt, StDiv, StEmitFin
  } be_state_e;

endpackage

// ===== rtl/core/kmeans_assign_and_update_2d_unit.sv =====
// Top level of the k-means assign/update unit: front queue plus back end.
// Point: search the active centroids one by one, then emit the result.
// Finish: x, y divides per non-empty cluster (one quotient bit a cycle); a result each.
// Load: done while idle. A two-entry queue lets the front accept while the back works.
// Reset clears centroids, sums, counts, changed counter; num_clusters becomes 4.
module kmeans_assign_and_update_2d_unit #(
  parameter int unsigned MaxClusters = kmau_pkg::MaxClustersDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [kmau_pkg::NumCfgW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [kmau_pkg::ModeW-1:0]   mode_i,
  input  logic [kmau_pkg::CoordW-1:0]  coord_x_i,
  input  logic [kmau_pkg::CoordW-1:0]  coord_y_i,
  input  logic [kmau_pkg::PrevW-1:0]   prev_cluster_i,
  input  logic [kmau_pkg::LoadW-1:0]   load_index_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [kmau_pkg::ClusW-1:0]   cluster_o,
  output logic                         changed_o,
  output logic [kmau_pkg::CoordW-1:0]  centroid_x_o,
  output logic [kmau_pkg::CoordW-1:0]  centroid_y_o,
  output logic [kmau_pkg::CntW-1:0]    cluster_size_o,
  output logic [kmau_pkg::CntW-1:0]    changed_total_o,
  output logic                         last_o
);
  import kmau_pkg::*;

  logic [NumCfgW-1:0] num_q;
  cmd_t cmd, q_cmd;
  logic q_valid, q_ready;

  assign cfg_ready_o = 1'b1;

  // Hold the cluster-count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) num_q <= NumClustersRst;
    else if (cfg_valid_i) num_q <= cfg_data_i;
  end

  assign cmd = '{mode: mode_i, x: coord_x_i, y: coord_y_i,
                 prev: prev_cluster_i, idx: load_index_i};

  kmau_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .cmd_i(cmd), .q_valid_o(q_valid), .q_ready_i(q_ready), .q_cmd_o(q_cmd)
  );

  kmau_back #(.MaxClusters(MaxClusters)) u_back (
    .clk_i, .rst_ni, .num_clusters_i(num_q),
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_cmd_i(q_cmd),
    .out_valid_o, .out_ready_i, .cluster_o, .changed_o, .centroid_x_o,
    .centroid_y_o, .cluster_size_o, .changed_total_o, .last_o
  );
endmodule

// ===== rtl/core/kmau_front.sv =====
// Front end: accept items, drop unknown modes, queue commands for the back end.
module kmau_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  kmau_pkg::cmd_t  cmd_i,
  output logic            q_valid_o,
  input  logic            q_ready_i,
  output kmau_pkg::cmd_t  q_cmd_o
);
  import kmau_pkg::*;

  cmd_t       buf_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       wp_q, rp_q;
  logic       push, pop;

  assign in_ready_o = (cnt_q != 2'd2);
  assign push = in_valid_i && in_ready_o && (cmd_i.mode != ModeNop);
  assign q_valid_o = (cnt_q != 2'd0);
  assign pop = q_valid_o && q_ready_i;
  assign q_cmd_o = buf_q[rp_q];

  always_comb begin
    cnt_d = cnt_q + 2'(push) - 2'(pop);
  end

  // Advance the two-entry queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wp_q] <= cmd_i;
  end
endmodule

// ===== rtl/core/kmau_div.sv =====
// Restoring divider: 36-bit dividend by 21-bit divisor, one quotient bit a cycle.
module kmau_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [kmau_pkg::SumW-1:0] num_i,
  input  logic [kmau_pkg::CntW-1:0] den_i,
  output logic                      done_o,
  output logic [kmau_pkg::SumW-1:0] quo_o
);
  import kmau_pkg::*;

  localparam int unsigned StepW = $clog2(SumW + 1);

  logic [SumW-1:0]  quo_q;
  logic [CntW:0]    rem_q;
  logic [CntW-1:0]  den_q;
  logic [StepW-1:0] step_q;
  logic             busy_q;
  logic [CntW:0]    trial;

  assign trial  = {rem_q[CntW-1:0], quo_q[SumW-1]};
  assign quo_o  = quo_q;
  assign done_o = busy_q && (step_q == StepW'(0));

  // Shift one quotient bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= StepW'(SumW);
    end else if (busy_q) begin
      if (step_q == StepW'(0)) busy_q <= 1'b0;
      else step_q <= step_q - StepW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q && step_q != StepW'(0)) begin
      if (trial >= {1'b0, den_q}) begin
        rem_q <= trial - {1'b0, den_q};
        quo_q <= {quo_q[SumW-2:0], 1'b1};
      end else begin
        rem_q <= trial;
        quo_q <= {quo_q[SumW-2:0], 1'b0};
      end
    end
  end
endmodule

// ===== rtl/core/kmau_back.sv =====
// Back end: centroid search, accumulation and end-of-pass centroid update.
module kmau_back #(
  parameter int unsigned MaxClusters = kmau_pkg::MaxClustersDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [kmau_pkg::NumCfgW-1:0] num_clusters_i,
  input  logic                         q_valid_i,
  output logic                         q_ready_o,
  input  kmau_pkg::cmd_t               q_cmd_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [kmau_pkg::ClusW-1:0]   cluster_o,
  output logic                         changed_o,
  output logic [kmau_pkg::CoordW-1:0]  centroid_x_o,
  output logic [kmau_pkg::CoordW-1:0]  centroid_y_o,
  output logic [kmau_pkg::CntW-1:0]    cluster_size_o,
  output logic [kmau_pkg::CntW-1:0]    changed_total_o,
  output logic                         last_o
);
  import kmau_pkg::*;

  localparam int unsigned IdxW = (MaxClusters > 1) ? $clog2(MaxClusters) : 1;
  localparam int unsigned KW = $clog2(MaxClusters + 1);
  localparam logic [SumW-1:0] SumMax = '1;
  localparam logic [CntW-1:0] CntMax = '1;

  logic [CoordW-1:0] cx_q [MaxClusters];
  logic [CoordW-1:0] cy_q [MaxClusters];
  logic [SumW-1:0]   sx_q [MaxClusters];
  logic [SumW-1:0]   sy_q [MaxClusters];
  logic [CntW-1:0]   cn_q [MaxClusters];
  logic [CntW-1:0]   chg_q;

  be_state_e state_q, state_d;
  cmd_t      cmd_q;
  logic [IdxW-1:0]   i_q;
  logic [IdxW-1:0]   best_q;
  logic [2*CoordW:0] bestd_q;
  logic [KW-1:0]     k;
  logic              div_start, div_done, div_y_q, div_busy_q;
  logic [SumW-1:0]   div_quo, div_num;
  logic [CoordW-1:0] mx_q;
  logic [CoordW-1:0] sat_quo;

  logic                 ov_q;
  logic [ClusW-1:0]     ov_cluster_q;
  logic                 ov_changed_q, ov_last_q;
  logic [CoordW-1:0]    ov_cx_q, ov_cy_q;
  logic [CntW-1:0]      ov_size_q, ov_tot_q;

  logic [CoordW-1:0] dx, dy;
  logic [2*CoordW:0] dist_sq;
  logic              last_i;
  logic              out_free;

  // Clamp cluster count
  always_comb begin
    if (num_clusters_i == '0) k = KW'(1);
    else if (32'(num_clusters_i) > MaxClusters) k = KW'(MaxClusters);
    else k = KW'(num_clusters_i);
  end

  assign last_i = (32'(i_q) + 1 >= 32'(k));
  assign out_free = !ov_q || out_ready_i;

  // Distance to centroid i_q
  always_comb begin
    dx = (cmd_q.x > cx_q[i_q]) ? cmd_q.x - cx_q[i_q] : cx_q[i_q] - cmd_q.x;
    dy = (cmd_q.y > cy_q[i_q]) ? cmd_q.y - cy_q[i_q] : cy_q[i_q] - cmd_q.y;
    dist_sq = (2*CoordW+1)'(dx * dx) + (2*CoordW+1)'(dy * dy);
  end

  assign div_num = div_y_q ? sy_q[i_q] : sx_q[i_q];
  assign sat_quo = (div_quo > SumW'(16'hFFFF)) ? 16'hFFFF : div_quo[CoordW-1:0];
  assign div_start = (state_q == StDiv) && !div_busy_q && (cn_q[i_q] != '0);

  kmau_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (cn_q[i_q]),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (q_valid_i) begin
          if (q_cmd_i.mode == ModePoint) state_d = StSearch;
          else if (q_cmd_i.mode == ModeFinish) state_d = StDiv;
        end
      end
      StSearch:  if (last_i) state_d = StEmitPt;
      StEmitPt:  if (out_free) state_d = StIdle;
      StDiv: begin
        if (cn_q[i_q] == '0 || (div_done && div_y_q)) state_d = StEmitFin;
      end
      StEmitFin: if (out_free) state_d = last_i ? StIdle : StDiv;
      default:   state_d = StIdle;
    endcase
  end

  assign q_ready_o = (state_q == StIdle);

  // Outputs
  always_comb begin
    out_valid_o     = ov_q;
    cluster_o       = ov_cluster_q;
    changed_o       = ov_changed_q;
    centroid_x_o    = ov_cx_q;
    centroid_y_o    = ov_cy_q;
    cluster_size_o  = ov_size_q;
    changed_total_o = ov_tot_q;
    last_o          = ov_last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      ov_q         <= 1'b0;
      ov_cluster_q <= '0;
      ov_changed_q <= 1'b0;
      ov_cx_q      <= '0;
      ov_cy_q      <= '0;
      ov_size_q    <= '0;
      ov_tot_q     <= '0;
      ov_last_q    <= 1'b0;
      div_busy_q   <= 1'b0;
      div_y_q      <= 1'b0;
      mx_q         <= '0;
      i_q          <= '0;
      best_q       <= '0;
      bestd_q      <= '0;
      chg_q        <= '0;
      for (int n = 0; n < MaxClusters; n++) begin
        cx_q[n] <= '0; cy_q[n] <= '0;
        sx_q[n] <= '0; sy_q[n] <= '0; cn_q[n] <= '0;
      end
    end else begin
      state_q <= state_d;
      // Hold the result until its transfer, then load the next one
      if ((state_q == StEmitPt || state_q == StEmitFin) && out_free) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
      case (state_q)
        StIdle: begin
          i_q <= '0;
          div_y_q <= 1'b0;
          if (q_valid_i && q_cmd_i.mode == ModeLoad && 32'(q_cmd_i.idx) < MaxClusters) begin
            cx_q[IdxW'(q_cmd_i.idx)] <= q_cmd_i.x;
            cy_q[IdxW'(q_cmd_i.idx)] <= q_cmd_i.y;
          end
        end
        StSearch: begin
          if (i_q == '0 || dist_sq < bestd_q) begin
            bestd_q <= dist_sq;
            best_q  <= i_q;
          end
          if (!last_i) i_q <= i_q + IdxW'(1);
        end
        StEmitPt: begin
          if (out_free) begin
            ov_cluster_q <= ClusW'(best_q);
            ov_changed_q <= (cmd_q.prev != PrevW'(best_q));
            ov_cx_q <= '0; ov_cy_q <= '0; ov_size_q <= '0; ov_tot_q <= '0;
            ov_last_q <= 1'b0;
            if (cmd_q.prev != PrevW'(best_q) && chg_q != CntMax) chg_q <= chg_q + CntW'(1);
            sx_q[best_q] <= (sx_q[best_q] > SumMax - SumW'(cmd_q.x)) ? SumMax
                            : sx_q[best_q] + SumW'(cmd_q.x);
            sy_q[best_q] <= (sy_q[best_q] > SumMax - SumW'(cmd_q.y)) ? SumMax
                            : sy_q[best_q] + SumW'(cmd_q.y);
            if (cn_q[best_q] != CntMax) cn_q[best_q] <= cn_q[best_q] + CntW'(1);
          end
        end
        StDiv: begin
          if (div_start) div_busy_q <= 1'b1;
          if (div_done) begin
            div_busy_q <= 1'b0;
            if (!div_y_q) begin
              mx_q <= sat_quo;
              div_y_q <= 1'b1;
            end else begin
              cx_q[i_q] <= mx_q;
              cy_q[i_q] <= sat_quo;
              div_y_q <= 1'b0;
            end
          end
        end
        StEmitFin: begin
          if (out_free) begin
            ov_cluster_q <= ClusW'(i_q);
            ov_changed_q <= 1'b0;
            ov_cx_q      <= cx_q[i_q];
            ov_cy_q      <= cy_q[i_q];
            ov_size_q    <= cn_q[i_q];
            ov_tot_q     <= chg_q;
            ov_last_q    <= last_i;
            if (last_i) begin
              chg_q <= '0;
              for (int n = 0; n < MaxClusters; n++) begin
                sx_q[n] <= '0; sy_q[n] <= '0; cn_q[n] <= '0;
              end
            end else begin
              i_q <= i_q + IdxW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && q_valid_i) cmd_q <= q_cmd_i;
  end
endmodule

// ===== sim/tb.sv =====
// Testbench for the k-means assign/update unit: directed and random passes.
`timescale 1ns / 100ps

module tb;
  import kmau_pkg::*;

  localparam int unsigned NumSlots  = MaxClustersDef;
  localparam int unsigned DrainWait = 80;

  typedef struct packed {
    logic [ClusW-1:0]  cluster;
    logic              changed;
    logic [CoordW-1:0] cx;
    logic [CoordW-1:0] cy;
    logic [CntW-1:0]   size;
    logic [CntW-1:0]   chg_total;
    logic              last;
  } kmeans_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [NumCfgW-1:0]  cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [ModeW-1:0]    mode_i = ModeLoad;
  logic [CoordW-1:0]   coord_x_i = '0;
  logic [CoordW-1:0]   coord_y_i = '0;
  logic [PrevW-1:0]    prev_cluster_i = '0;
  logic [LoadW-1:0]    load_index_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [ClusW-1:0]    cluster_o;
  logic                changed_o;
  logic [CoordW-1:0]   centroid_x_o;
  logic [CoordW-1:0]   centroid_y_o;
  logic [CntW-1:0]     cluster_size_o;
  logic [CntW-1:0]     changed_total_o;
  logic                last_o;

  kmeans_assign_and_update_2d_unit u_dut (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .in_valid_i, .in_ready_o, .mode_i, .coord_x_i, .coord_y_i,
    .prev_cluster_i, .load_index_i,
    .out_valid_o, .out_ready_i, .cluster_o, .changed_o, .centroid_x_o,
    .centroid_y_o, .cluster_size_o, .changed_total_o, .last_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the clustering state
  logic [NumCfgW-1:0] num_clusters_q;
  logic [CoordW-1:0]  cent_x [NumSlots];
  logic [CoordW-1:0]  cent_y [NumSlots];
  logic [SumW-1:0]    sum_x [NumSlots];
  logic [SumW-1:0]    sum_y [NumSlots];
  logic [CntW-1:0]    members [NumSlots];
  logic [CntW-1:0]    moved_count;

  kmeans_result_t pending_results[$];
  int  mismatches = 0;
  bit  quiet_mode = 1'b0;

  function automatic int unsigned active_count();
    if (num_clusters_q == 0) return 1;
    if (num_clusters_q > NumSlots) return NumSlots;
    return num_clusters_q;
  endfunction

  function automatic logic [SumW-1:0] sat_sum(logic [SumW-1:0] a, logic [CoordW-1:0] b);
    logic [SumW:0] s;
    s = {1'b0, a} + b;
    return s[SumW] ? '1 : s[SumW-1:0];
  endfunction

  function automatic logic [CntW-1:0] sat_inc(logic [CntW-1:0] a);
    return (a == '1) ? a : a + 1'b1;
  endfunction

  function automatic logic [32:0] sq_dist(logic [CoordW-1:0] px, logic [CoordW-1:0] py,
                                          logic [CoordW-1:0] qx, logic [CoordW-1:0] qy);
    logic [CoordW-1:0] dx, dy;
    dx = (px > qx) ? px - qx : qx - px;
    dy = (py > qy) ? py - qy : qy - py;
    return 33'(dx * dx) + 33'(dy * dy);
  endfunction

  // Apply one accepted command to the shadow state and queue its results
  function automatic void predict_command(logic [ModeW-1:0] mode, logic [CoordW-1:0] x,
                                          logic [CoordW-1:0] y, logic [PrevW-1:0] prev,
                                          logic [LoadW-1:0] idx);
    int unsigned k;
    int unsigned best;
    logic [32:0] best_d, d;
    logic [SumW-1:0] mx, my;
    kmeans_result_t r;
    k = active_count();
    case (mode)
      ModeLoad: begin
        cent_x[idx] = x;
        cent_y[idx] = y;
      end
      ModePoint: begin
        best = 0;
        best_d = sq_dist(x, y, cent_x[0], cent_y[0]);
        for (int i = 1; i < k; i++) begin
          d = sq_dist(x, y, cent_x[i], cent_y[i]);
          if (d < best_d) begin
            best_d = d;
            best = i;
          end
        end
        r = '0;
        r.cluster = ClusW'(best);
        r.changed = (prev != best);
        if (r.changed) moved_count = sat_inc(moved_count);
        sum_x[best] = sat_sum(sum_x[best], x);
        sum_y[best] = sat_sum(sum_y[best], y);
        members[best] = sat_inc(members[best]);
        pending_results.push_back(r);
      end
      ModeFinish: begin
        for (int i = 0; i < k; i++) begin
          if (members[i] != 0) begin
            mx = sum_x[i] / members[i];
            my = sum_y[i] / members[i];
            cent_x[i] = (mx > 16'hFFFF) ? 16'hFFFF : mx[CoordW-1:0];
            cent_y[i] = (my > 16'hFFFF) ? 16'hFFFF : my[CoordW-1:0];
          end
          r = '0;
          r.cluster = ClusW'(i);
          r.cx = cent_x[i];
          r.cy = cent_y[i];
          r.size = members[i];
          r.chg_total = moved_count;
          r.last = (i + 1 == k);
          pending_results.push_back(r);
        end
        for (int i = 0; i < NumSlots; i++) begin
          sum_x[i] = '0;
          sum_y[i] = '0;
          members[i] = '0;
        end
        moved_count = '0;
      end
      default: ;
    endcase
  endfunction

  function automatic int unsigned draw_gap();
    return quiet_mode ? 0 : $urandom_range(0, 9);
  endfunction

  // Send one command; valid stays up between back-to-back transfers
  task automatic send_command(logic [ModeW-1:0] mode, logic [CoordW-1:0] x,
                              logic [CoordW-1:0] y, logic [PrevW-1:0] prev,
                              logic [LoadW-1:0] idx);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    mode_i = mode;
    coord_x_i = x;
    coord_y_i = y;
    prev_cluster_i = prev;
    load_index_i = idx;
    do @(posedge clk_i); while (!in_ready_o);
    predict_command(mode, x, y, prev, idx);
    @(negedge clk_i);
  endtask

  task automatic load_centroid(int unsigned idx, logic [CoordW-1:0] x, logic [CoordW-1:0] y);
    send_command(ModeLoad, x, y, PrevW'($urandom), LoadW'(idx));
  endtask

  task automatic send_point(logic [CoordW-1:0] x, logic [CoordW-1:0] y,
                            logic [PrevW-1:0] prev);
    send_command(ModePoint, x, y, prev, LoadW'($urandom));
  endtask

  task automatic finish_pass();
    send_command(ModeFinish, CoordW'($urandom), CoordW'($urandom), PrevW'($urandom),
                 LoadW'($urandom));
  endtask

  task automatic send_noise();
    send_command(ModeNop, CoordW'($urandom), CoordW'($urandom), PrevW'($urandom),
                 LoadW'($urandom));
  endtask

  // Drain all results, let queued loads settle, then write the cluster count
  task automatic set_num_clusters(logic [NumCfgW-1:0] value);
    in_valid_i = 1'b0;
    wait (pending_results.size() == 0);
    repeat (DrainWait) @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    num_clusters_q = value;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Before any load all centroids are zero, so every point lands on cluster 0
  task automatic test_reset_state();
    send_point(16'h1234, 16'hABCD, 5'd16);
    send_point(16'h0000, 16'h0000, 5'd0);
    finish_pass();
  endtask

  // Coordinate and index extremes, ties, odd previous clusters, unknown mode
  task automatic test_extremes();
    set_num_clusters(5'd16);
    for (int i = 0; i < 16; i++) load_centroid(i, 16'h0000, 16'h0000);
    load_centroid(15, 16'hFFFF, 16'hFFFF);
    load_centroid(3, 16'h8000, 16'h8000);
    send_point(16'hFFFF, 16'hFFFF, 5'd15);
    send_point(16'h0000, 16'h0000, 5'd31);
    send_point(16'h4000, 16'h4000, 5'd16);
    send_point(16'hFFFF, 16'h0000, 5'd3);
    send_noise();
    send_point(16'h7FFF, 16'h8001, 5'd0);
    finish_pass();
  endtask

  // Cluster counts outside the legal range and the smallest setting
  task automatic test_cluster_counts();
    set_num_clusters(5'd0);
    send_point(16'hFFFF, 16'h0001, 5'd0);
    finish_pass();
    set_num_clusters(5'd31);
    load_centroid(12, 16'hF000, 16'h0F00);
    send_point(16'hF0F0, 16'h0F0F, 5'd12);
    finish_pass();
    set_num_clusters(5'd1);
    load_centroid(9, 16'h5555, 16'hAAAA);
    send_point(16'hAAAA, 16'h5555, 5'd9);
    finish_pass();
  endtask

  // Full Lloyd passes with random content, mixed with noise
  task automatic test_random_passes();
    int unsigned sent;
    int unsigned k;
    int unsigned npts;
    logic [NumCfgW-1:0] cfg;
    sent = 0;
    while (sent < 260) begin
      case ($urandom_range(0, 5))
        0: cfg = 5'd16;
        1: cfg = 5'd1;
        2: cfg = NumCfgW'($urandom_range(17, 31));
        default: cfg = NumCfgW'($urandom_range(2, 8));
      endcase
      quiet_mode = ($urandom_range(0, 3) == 0);
      set_num_clusters(cfg);
      k = active_count();
      for (int i = 0; i < k; i++) begin
        load_centroid(i, CoordW'($urandom), CoordW'($urandom));
        sent++;
      end
      for (int iter = 0; iter < 2; iter++) begin
        npts = $urandom_range(4, 20);
        for (int p = 0; p < npts; p++) begin
          if ($urandom_range(0, 9) == 0) send_noise();
          if ($urandom_range(0, 14) == 0) begin
            load_centroid($urandom_range(0, 15), CoordW'($urandom), CoordW'($urandom));
            sent++;
          end
          send_point(CoordW'($urandom), CoordW'($urandom),
                     ($urandom_range(0, 4) == 0) ? PrevW'($urandom_range(0, 31))
                                                 : PrevW'($urandom_range(0, k - 1)));
          sent++;
        end
        finish_pass();
        sent++;
      end
    end
    quiet_mode = 1'b0;
  endtask

  // Result side: random stall before each transfer
  initial begin
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        out_ready_i = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  // Compare every transfer with the oldest expectation
  always @(posedge clk_i) begin
    kmeans_result_t got, want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{cluster_o, changed_o, centroid_x_o, centroid_y_o, cluster_size_o,
              changed_total_o, last_o};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  initial begin
    #50_000_000;
    $display("** kmeans_assign_and_update_2d_unit: FAILED **");
    $finish;
  end

  initial begin
    int unsigned settle;
    num_clusters_q = NumClustersRst;
    for (int i = 0; i < NumSlots; i++) begin
      cent_x[i] = '0;
      cent_y[i] = '0;
      sum_x[i] = '0;
      sum_y[i] = '0;
      members[i] = '0;
    end
    moved_count = '0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_reset_state();
    test_extremes();
    test_cluster_counts();
    test_random_passes();
    in_valid_i = 1'b0;
    wait (pending_results.size() == 0);
    settle = 0;
    while (settle < 200) begin
      @(negedge clk_i);
      settle++;
    end
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("** kmeans_assign_and_update_2d_unit: PASSED **");
    end else begin
      $display("** kmeans_assign_and_update_2d_unit: FAILED **");
    end
    $finish;
  end

endmodule

// ===== kmeans_assign_and_update_2d_unit.f =====
rtl/core/kmau_pkg.sv
rtl/core/kmau_front.sv
rtl/core/kmau_div.sv
rtl/core/kmau_back.sv
rtl/core/kmeans_assign_and_update_2d_unit.sv
sim/tb.sv
